[rtl/spq_pkg.sv]
// Shared types, status codes and defaults for the sorted-insert priority queue.
package spq_pkg;

  // Default number of cells
  localparam int unsigned DEPTH = 16;

  // Operation codes
  localparam logic OP_STORE    = 1'b0;
  localparam logic OP_RETRIEVE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic               ins;  // insert beat, store not full
    logic               rem;  // remove beat, store not empty
    logic signed [31:0] val;  // value being inserted
  } cell_ctrl_t;

endpackage

[rtl/spq_cell.sv]
// One cell of the sorted shift chain: holds a value and moves it left or right.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                in_use_i,    // cell holds a live entry
  input  logic                prev_gt_i,   // left neighbor is greater than new value
  input  logic signed [31:0]  prev_val_i,  // left neighbor's value
  input  logic signed [31:0]  next_val_i,  // right neighbor's value
  output logic                gt_o,        // this cell moves right on insert
  output logic signed [31:0]  val_o
);

  logic signed [31:0] entry_q;
  logic signed [31:0] entry_d;

  // Empty cells count as greater so the new value lands at the tail
  assign gt_o  = in_use_i ? (entry_q > ctrl_i.val) : 1'b1;
  assign val_o = entry_q;

  // Insert: the first greater cell takes the new value, later ones shift right
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && gt_o) begin
      entry_d = prev_gt_i ? prev_val_i : ctrl_i.val;
    end else if (ctrl_i.rem) begin
      entry_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[rtl/sorted_insert_priority_queue.sv]
// Top level: sorted-insert min-priority queue built as a chain of shift cells.
//
// A bounded min-priority queue of signed 32-bit values. Each start beat
// (start high, busy low) carries one operation, and exactly one result
// follows in the next cycle on done_o; busy never rises, so one operation
// is taken every clock cycle. All DEPTH cells compare their value with the
// new one in parallel and shift right or left in the same cycle. The result
// must be taken when done_o is high: there is no way to stall it. Store
// places a value after all equal ones; retrieve returns the smallest (oldest
// among equals), or 0 with an empty status; store on a full queue is
// dropped with a full status.
module sorted_insert_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               opcode_i,
  input  logic signed [31:0] value_in_i,
  output logic               done_o,
  output logic signed [31:0] value_out_o,
  output logic [1:0]         status_o,
  output logic [4:0]         occupancy_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]     count_q, count_d;
  logic                accept;
  logic                is_full, is_empty;
  spq_pkg::cell_ctrl_t ctrl;

  logic signed [31:0]  cell_val [DEPTH];
  logic [DEPTH-1:0]    cell_gt;
  logic [DEPTH-1:0]    cell_in_use;

  logic                done_q;
  logic signed [31:0]  value_out_q, value_out_d;
  logic [1:0]          status_q, status_d;
  logic [CntW+4:0]     occ_ext;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  // Control broadcast to the cell row
  assign ctrl.ins = accept && (opcode_i == spq_pkg::OP_STORE) && !is_full;
  assign ctrl.rem = accept && (opcode_i == spq_pkg::OP_RETRIEVE) && !is_empty;
  assign ctrl.val = value_in_i;

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               prev_gt;
    logic signed [31:0] prev_val;
    logic signed [31:0] next_val;

    assign cell_in_use[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = cell_val[0];
    end else begin : g_mid
      assign prev_gt  = cell_gt[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .in_use_i   (cell_in_use[i]),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .gt_o       (cell_gt[i]),
      .val_o      (cell_val[i])
    );
  end

  // Count and result
  always_comb begin
    count_d     = count_q;
    value_out_d = '0;
    status_d    = spq_pkg::ST_OK;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem) begin
      count_d     = count_q - CntW'(1);
      value_out_d = cell_val[0];
    end
    if (accept && (opcode_i == spq_pkg::OP_STORE) && is_full) begin
      status_d = spq_pkg::ST_FULL;
    end else if (accept && (opcode_i == spq_pkg::OP_RETRIEVE) && is_empty) begin
      status_d = spq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_out_q <= value_out_d;
      status_q    <= status_d;
    end
  end

  assign occ_ext     = {5'b0, count_q};
  assign done_o      = done_q;
  assign value_out_o = value_out_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_ext[4:0];

  // Checks
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o) else $error("result beat missing after start");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o) else $error("result beat without start");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH)) else $error("entry count beyond depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == spq_pkg::ST_FULL) |-> is_full)
    else $error("full status while not full");

endmodule
